// File: hw/rtl/msp_pkg.sv
package msp_pkg;

    // fixed field widths
    localparam int CFG_W     = 7;
    localparam int OUT_IDX_W = 6;
    localparam int UPC_W     = 4;

    typedef logic [UPC_W-1:0] t_upc;

    // program addresses
    localparam t_upc UPC_LOAD    = 4'd0;
    localparam t_upc UPC_RFETCH  = 4'd1;
    localparam t_upc UPC_RFIRST  = 4'd2;
    localparam t_upc UPC_RSCAN   = 4'd3;
    localparam t_upc UPC_KFETCH  = 4'd4;
    localparam t_upc UPC_KSCAN   = 4'd5;
    localparam t_upc UPC_CHECK   = 4'd6;
    localparam t_upc UPC_NEXTROW = 4'd7;
    localparam t_upc UPC_EMIT    = 4'd8;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_LOAD_DONE,
        COND_ROW_DONE,
        COND_COL_END,
        COND_SADDLE,
        COND_MORE_ROWS,
        COND_OUT_FREE
    } t_cond;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ROW_FETCH,
        ACT_ROW_FIRST,
        ACT_ROW_CMP,
        ACT_COL_FETCH,
        ACT_COL_CMP,
        ACT_NEXT_ROW,
        ACT_EMIT
    } t_act;

    typedef enum logic {
        SEL_ROW,
        SEL_COL
    } t_rd_sel;

    typedef struct packed {
        t_act    act;
        t_rd_sel rd_sel;
        t_cond   cond;
        logic    hold;
        t_upc    jump;
    } t_uword;

    typedef struct packed {
        logic load_done;
        logic row_done;
        logic col_end;
        logic saddle;
        logic more_rows;
        logic out_free;
    } t_stat;

    // control store
    function automatic t_uword ucode(t_upc upc);
        t_uword w;
        case (upc)
            UPC_LOAD:    w = '{ACT_LOAD,      SEL_ROW, COND_LOAD_DONE, 1'b1, UPC_RFETCH};
            UPC_RFETCH:  w = '{ACT_ROW_FETCH, SEL_ROW, COND_NONE,      1'b0, UPC_LOAD};
            UPC_RFIRST:  w = '{ACT_ROW_FIRST, SEL_ROW, COND_ROW_DONE,  1'b0, UPC_KFETCH};
            UPC_RSCAN:   w = '{ACT_ROW_CMP,   SEL_ROW, COND_ROW_DONE,  1'b1, UPC_KFETCH};
            UPC_KFETCH:  w = '{ACT_COL_FETCH, SEL_COL, COND_NONE,      1'b0, UPC_LOAD};
            UPC_KSCAN:   w = '{ACT_COL_CMP,   SEL_COL, COND_COL_END,   1'b1, UPC_CHECK};
            UPC_CHECK:   w = '{ACT_NONE,      SEL_ROW, COND_SADDLE,    1'b0, UPC_EMIT};
            UPC_NEXTROW: w = '{ACT_NEXT_ROW,  SEL_ROW, COND_MORE_ROWS, 1'b0, UPC_RFETCH};
            UPC_EMIT:    w = '{ACT_EMIT,      SEL_ROW, COND_OUT_FREE,  1'b1, UPC_LOAD};
            default:     w = '{ACT_NONE,      SEL_ROW, COND_ALWAYS,    1'b0, UPC_LOAD};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/msp_if.sv
interface msp_cfg_if import msp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] matrix_size;

    modport source (output valid, output matrix_size, input ready);
    modport sink   (input valid, input matrix_size, output ready);
endinterface

interface msp_elem_if #(
    parameter int VALUE_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface msp_res_if import msp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [OUT_IDX_W-1:0] row_index;
    logic [OUT_IDX_W-1:0] column_index;

    modport source (output valid, output found, output row_index, output column_index,
                    input ready);
    modport sink   (input valid, input found, input row_index, input column_index,
                    output ready);
endinterface

// File: hw/rtl/msp_ram.sv
module msp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/msp_useq.sv
module msp_useq import msp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stat  i_stat,
    output t_uword o_ctrl
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   cond_true;

    assign uw = ucode(r_upc);

    always_comb begin
        case (uw.cond)
            COND_NONE:      cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_LOAD_DONE: cond_true = i_stat.load_done;
            COND_ROW_DONE:  cond_true = i_stat.row_done;
            COND_COL_END:   cond_true = i_stat.col_end;
            COND_SADDLE:    cond_true = i_stat.saddle;
            COND_MORE_ROWS: cond_true = i_stat.more_rows;
            COND_OUT_FREE:  cond_true = i_stat.out_free;
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (cond_true) begin
            n_upc = uw.jump;
        end else if (uw.hold) begin
            n_upc = r_upc;
        end else begin
            n_upc = r_upc + t_upc'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_LOAD;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctrl = uw;

endmodule

// File: hw/rtl/msp_dpath.sv
module msp_dpath import msp_pkg::*; #(
    parameter int MAX_SIZE    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_uword                        i_ctrl,
    output t_stat                         o_stat,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_W-1:0]              i_cfg_size,
    input  logic                          i_elem_valid,
    output logic                          o_elem_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_elem_value,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output logic                          o_res_found,
    output logic [OUT_IDX_W-1:0]          o_res_row,
    output logic [OUT_IDX_W-1:0]          o_res_col
);

    localparam int IDX_W  = MAX_SIZE > 1 ? $clog2(MAX_SIZE) : 1;
    localparam int CNT_W  = $clog2(MAX_SIZE + 1);
    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int LCNT_W = $clog2(DEPTH + 1);
    localparam int AFUL_W = IDX_W + CNT_W + 1;
    localparam int EXT_W  = IDX_W + OUT_IDX_W;

    // size and load bookkeeping
    logic [CNT_W-1:0]  r_size;
    logic [CNT_W-1:0]  n_size;
    logic [LCNT_W-1:0] r_total;
    logic [LCNT_W-1:0] n_total;
    logic [LCNT_W-1:0] r_load_cnt;

    // scan registers
    logic [IDX_W-1:0]              r_row;
    logic [CNT_W-1:0]              r_col;
    logic [CNT_W-1:0]              r_k;
    logic [IDX_W-1:0]              r_best;
    logic signed [VALUE_WIDTH-1:0] r_bval;
    logic                          r_ok;

    // result register
    logic                 r_res_valid;
    logic                 r_found;
    logic [OUT_IDX_W-1:0] r_row_out;
    logic [OUT_IDX_W-1:0] r_col_out;

    logic                          elem_xfer;
    logic                          load_done;
    logic                          out_free;
    logic signed [VALUE_WIDTH-1:0] rdata;
    logic [ADDR_W-1:0]             raddr;
    logic [AFUL_W-1:0]             addr_full;
    logic [IDX_W-1:0]              op_row;
    logic [CNT_W-1:0]              op_col;
    logic                          less;
    logic                          greater;
    logic [EXT_W-1:0]              row_ext;
    logic [EXT_W-1:0]              best_ext;

    // size 0 reads as 1, anything above the store saturates
    always_comb begin
        if (i_cfg_size == '0) begin
            n_size = CNT_W'(1);
        end else if ((CNT_W + CFG_W)'(i_cfg_size) > (CNT_W + CFG_W)'(MAX_SIZE)) begin
            n_size = CNT_W'(MAX_SIZE);
        end else begin
            n_size = CNT_W'(i_cfg_size);
        end
        n_total = LCNT_W'(n_size) * LCNT_W'(n_size);
    end

    assign o_cfg_ready  = 1'b1;
    assign o_elem_ready = (i_ctrl.act == ACT_LOAD);
    assign elem_xfer    = i_elem_valid && o_elem_ready;
    assign load_done    = elem_xfer && (r_load_cnt == r_total - LCNT_W'(1));
    assign out_free     = !r_res_valid || i_res_ready;

    // one multiplier shared by row and column walks
    assign op_row    = (i_ctrl.rd_sel == SEL_ROW) ? r_row : r_k[IDX_W-1:0];
    assign op_col    = (i_ctrl.rd_sel == SEL_ROW) ? r_col : CNT_W'(r_best);
    assign addr_full = AFUL_W'(op_row) * AFUL_W'(r_size) + AFUL_W'(op_col);
    assign raddr     = addr_full[ADDR_W-1:0];

    msp_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (elem_xfer),
        .i_waddr (r_load_cnt[ADDR_W-1:0]),
        .i_wdata (i_elem_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign less    = rdata < r_bval;
    assign greater = rdata > r_bval;

    assign o_stat.load_done = load_done;
    assign o_stat.row_done  = (r_col == r_size);
    assign o_stat.col_end   = less || (r_k == r_size);
    assign o_stat.saddle    = r_ok;
    assign o_stat.more_rows = (CNT_W'(r_row) != r_size - CNT_W'(1));
    assign o_stat.out_free  = out_free;

    assign row_ext  = EXT_W'(r_row);
    assign best_ext = EXT_W'(r_best);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= CNT_W'(1);
            r_total     <= LCNT_W'(1);
            r_load_cnt  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size     <= n_size;
                r_total    <= n_total;
                r_load_cnt <= '0;
            end else if (elem_xfer) begin
                r_load_cnt <= load_done ? '0 : r_load_cnt + LCNT_W'(1);
            end
            if (i_ctrl.act == ACT_EMIT && out_free) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // read data comes from the registered read port of the store
    always_ff @(posedge i_clk) begin
        case (i_ctrl.act)
            ACT_LOAD: begin
                if (load_done) begin
                    r_row <= '0;
                    r_col <= '0;
                end
            end
            ACT_ROW_FETCH: begin
                r_col <= CNT_W'(1);
                r_k   <= '0;
            end
            ACT_ROW_FIRST: begin
                r_bval <= rdata;
                r_best <= '0;
                r_col  <= r_col + CNT_W'(1);
            end
            ACT_ROW_CMP: begin
                // ties keep the earlier column
                if (greater) begin
                    r_bval <= rdata;
                    r_best <= IDX_W'(r_col - CNT_W'(1));
                end
                r_col <= r_col + CNT_W'(1);
            end
            ACT_COL_FETCH: begin
                r_k  <= CNT_W'(1);
                r_ok <= 1'b1;
            end
            ACT_COL_CMP: begin
                if (less) begin
                    r_ok <= 1'b0;
                end
                r_k <= r_k + CNT_W'(1);
            end
            ACT_NEXT_ROW: begin
                r_row <= r_row + IDX_W'(1);
                r_col <= '0;
            end
            ACT_EMIT: begin
                if (out_free) begin
                    r_found   <= r_ok;
                    r_row_out <= r_ok ? row_ext[OUT_IDX_W-1:0] : '0;
                    r_col_out <= r_ok ? best_ext[OUT_IDX_W-1:0] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res_valid = r_res_valid;
    assign o_res_found = r_found;
    assign o_res_row   = r_row_out;
    assign o_res_col   = r_col_out;

endmodule

// File: hw/rtl/matrix_saddle_point_finder.sv
// saddle point search over a square signed matrix of n x n elements
// i_cfg: writes n (matrix_size); 0 reads as 1, values above MAX_SIZE saturate.
//   a write restarts loading and is taken at once while the block is idle
// i_elem: elements in row-major order, one per transfer; during loading one
//   element is taken every cycle and written straight into the matrix store;
//   ready stays low while a scan runs
// o_result: after the n*n-th element one result (found, row, column);
//   row and column read 0 when no saddle point exists
// the scan after the last element is paced by the single read port of the matrix
//   store and the microprogram walking one element per cycle
// a finished result waits in an output register; loading of the next matrix
//   goes on meanwhile, and the scan only stalls at its end if that register is
//   still full when a further result is ready
// after reset n is 1, the load count is 0 and no result is pending; the store
//   needs no clearing, as a scan only reads entries loaded for that matrix
module matrix_saddle_point_finder import msp_pkg::*; #(
    parameter int MAX_SIZE    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    msp_cfg_if.sink      i_cfg,
    msp_elem_if.sink     i_elem,
    msp_res_if.source    o_result
);

    t_uword ctrl;
    t_stat  stat;

    msp_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    msp_dpath #(
        .MAX_SIZE    (MAX_SIZE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_cfg_valid  (i_cfg.valid),
        .o_cfg_ready  (i_cfg.ready),
        .i_cfg_size   (i_cfg.matrix_size),
        .i_elem_valid (i_elem.valid),
        .o_elem_ready (i_elem.ready),
        .i_elem_value (i_elem.element_value),
        .o_res_valid  (o_result.valid),
        .i_res_ready  (o_result.ready),
        .o_res_found  (o_result.found),
        .o_res_row    (o_result.row_index),
        .o_res_col    (o_result.column_index)
    );

endmodule
